### src/kdt_pkg.sv
package kdt_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W = 32;
    localparam int DIST_W = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_INSERTED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SWEEP
    } t_state;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [DIST_W-1:0]   distance;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    clr_idx;
        logic    inc_idx;
        logic    note_free;
        logic    write;
        logic    write_valid;
        logic    use_free;
        logic    respond;
        t_status resp_status;
        logic    resp_hit_dist;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic last;
        logic free_avail;
        t_op  op;
    } t_sts;

endpackage

### src/kdt_ctrl.sv
module kdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_operation,
    input  kdt_pkg::t_sts i_sts,
    output kdt_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    kdt_pkg::t_state r_state;
    kdt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kdt_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            kdt_pkg::S_INIT: begin
                o_cmd.write       = 1'b1;
                o_cmd.write_valid = 1'b0;
                if (i_sts.last) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = kdt_pkg::S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            kdt_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    if (kdt_pkg::t_op'(i_operation) == kdt_pkg::OP_CLEAR) begin
                        n_state = kdt_pkg::S_SWEEP;
                    end else begin
                        n_state = kdt_pkg::S_READ;
                    end
                end
            end
            kdt_pkg::S_READ: begin
                n_state = kdt_pkg::S_CHECK;
            end
            kdt_pkg::S_CHECK: begin
                o_cmd.note_free = 1'b1;
                if (i_sts.match) begin
                    o_cmd.respond     = 1'b1;
                    o_cmd.resp_status = kdt_pkg::ST_DONE;
                    n_state           = kdt_pkg::S_IDLE;
                    case (i_sts.op)
                        kdt_pkg::OP_LOOKUP: begin
                            o_cmd.resp_hit_dist = 1'b1;
                        end
                        kdt_pkg::OP_UPDATE: begin
                            o_cmd.write       = 1'b1;
                            o_cmd.write_valid = 1'b1;
                        end
                        default: begin
                            o_cmd.write       = 1'b1;
                            o_cmd.write_valid = 1'b0;
                        end
                    endcase
                end else if (i_sts.last) begin
                    o_cmd.respond = 1'b1;
                    n_state       = kdt_pkg::S_IDLE;
                    if (i_sts.op == kdt_pkg::OP_UPDATE) begin
                        if (i_sts.free_avail) begin
                            o_cmd.write       = 1'b1;
                            o_cmd.write_valid = 1'b1;
                            o_cmd.use_free    = 1'b1;
                            o_cmd.resp_status = kdt_pkg::ST_INSERTED;
                        end else begin
                            o_cmd.resp_status = kdt_pkg::ST_FULL;
                        end
                    end else begin
                        o_cmd.resp_status = kdt_pkg::ST_MISSING;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = kdt_pkg::S_READ;
                end
            end
            kdt_pkg::S_SWEEP: begin
                o_cmd.write       = 1'b1;
                o_cmd.write_valid = 1'b0;
                if (i_sts.last) begin
                    o_cmd.respond     = 1'b1;
                    o_cmd.resp_status = kdt_pkg::ST_DONE;
                    n_state           = kdt_pkg::S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            default: begin
                n_state = kdt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != kdt_pkg::S_IDLE);

    a_respond_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.respond |-> (r_state == kdt_pkg::S_CHECK || r_state == kdt_pkg::S_SWEEP))
        else $error("result issued outside check or sweep");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> (r_state != kdt_pkg::S_IDLE && r_state != kdt_pkg::S_READ))
        else $error("table write while idle or reading");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy)
        else $error("request taken but not busy");

    a_insert_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.use_free |-> (!i_sts.match && i_sts.last && i_sts.free_avail))
        else $error("insert without full scan or free slot");

endmodule

### src/kdt_dpath.sv
module kdt_dpath #(
    parameter int ENTRIES = kdt_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_operation,
    input  logic [kdt_pkg::KEY_W-1:0]  i_node_address,
    input  logic [kdt_pkg::DIST_W-1:0] i_distance_in,
    input  kdt_pkg::t_cmd              i_cmd,
    output kdt_pkg::t_sts              o_sts,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [kdt_pkg::DIST_W-1:0] o_distance_out
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    kdt_pkg::t_entry mem [ENTRIES];
    kdt_pkg::t_entry r_rd;

    kdt_pkg::t_op               r_op;
    logic [kdt_pkg::KEY_W-1:0]  r_key;
    logic [kdt_pkg::DIST_W-1:0] r_dist;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              n_idx;
    logic                       r_free_found;
    logic                       n_free_found;
    logic [AW-1:0]              r_free_idx;
    logic [AW-1:0]              free_addr;
    logic [AW-1:0]              wr_addr;
    kdt_pkg::t_entry            wr_entry;
    logic                       r_strobe;
    kdt_pkg::t_status           r_status;
    logic [kdt_pkg::DIST_W-1:0] r_dout;

    // storage, registered read of the current slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[wr_addr] <= wr_entry;
        end
        r_rd <= mem[r_idx];
    end

    assign free_addr         = r_free_found ? r_free_idx : r_idx;
    assign wr_addr           = i_cmd.use_free ? free_addr : r_idx;
    assign wr_entry.valid    = i_cmd.write_valid;
    assign wr_entry.key      = r_key;
    assign wr_entry.distance = r_dist;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end else if (i_cmd.inc_idx) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_comb begin
        n_free_found = r_free_found;
        if (i_cmd.load) begin
            n_free_found = 1'b0;
        end else if (i_cmd.note_free && !r_rd.valid) begin
            n_free_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
            r_strobe     <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= kdt_pkg::t_op'(i_operation);
            r_key  <= i_node_address;
            r_dist <= i_distance_in;
        end
        if (i_cmd.note_free && !r_rd.valid && !r_free_found) begin
            r_free_idx <= r_idx;
        end
        if (i_cmd.respond) begin
            r_status <= i_cmd.resp_status;
            r_dout   <= i_cmd.resp_hit_dist ? r_rd.distance : '0;
        end
    end

    assign o_sts.match      = r_rd.valid && (r_rd.key == r_key);
    assign o_sts.last       = (r_idx == LAST_IDX);
    assign o_sts.free_avail = r_free_found || !r_rd.valid;
    assign o_sts.op         = r_op;

    assign o_done         = r_strobe;
    assign o_status       = r_status;
    assign o_distance_out = r_dout;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_idx |-> (r_idx != LAST_IDX))
        else $error("slot index stepped past last entry");

    a_free_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.note_free && !r_rd.valid && !r_free_found) |=> r_free_found)
        else $error("free slot not recorded");

    a_hit_dist_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.resp_hit_dist |-> o_sts.match)
        else $error("distance returned without a key match");

endmodule

### src/keyed_distance_table.sv
// channel   | direction | ports                                           | handshake
// request   | in        | i_operation, i_node_address, i_distance_in      | i_start && !o_busy
// result    | out       | o_status, o_distance_out                        | o_done, one cycle
//
// a request scans the table slot by slot through S_READ and S_CHECK (one read port, registered read data):
// a hit ends the scan at the matching slot, a miss or an insert visits every slot,
// clear writes every slot in S_SWEEP; the result follows on the cycle after the last slot.
// after reset a clearing pass over every slot (S_INIT) runs with o_busy high and no result.
// reset is synchronous, active low; the receiver cannot stall, o_done lasts one cycle.
module keyed_distance_table #(
    parameter int ENTRIES = kdt_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_operation,
    input  logic [kdt_pkg::KEY_W-1:0]  i_node_address,
    input  logic [kdt_pkg::DIST_W-1:0] i_distance_in,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [kdt_pkg::DIST_W-1:0] o_distance_out
);

    kdt_pkg::t_cmd cmd;
    kdt_pkg::t_sts sts;

    kdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    kdt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_node_address (i_node_address),
        .i_distance_in  (i_distance_in),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_distance_out (o_distance_out)
    );

endmodule
